### hw/rtl/sst_pkg.sv
// shared types and constants for the sorted session table
package sst_pkg;

  localparam int TABLE_CAPACITY = 256;
  localparam int MAX_PER_USER   = 8;
  localparam int CNT_W          = $clog2(TABLE_CAPACITY + 1);
  localparam int LIST_W         = $clog2(MAX_PER_USER + 1);

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_LIST   = 2'd2;
  localparam logic [1:0] REQ_FLUSH  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_USER_MAX  = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] user_id;
    logic [31:0] peer_ip;
    logic [31:0] account_num;
    logic [63:0] secret_hi;
    logic [63:0] secret_lo;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_user_id;
    logic [31:0] out_peer_ip;
    logic [31:0] out_account;
    logic [63:0] out_secret_hi;
    logic [63:0] out_secret_lo;
    logic [31:0] out_sequence;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] account;
    logic [63:0] secret_hi;
    logic [63:0] secret_lo;
    logic [31:0] sequence_num;
  } entry_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CMP,
    PH_INS,
    PH_DEL,
    PH_UPD,
    PH_LSTART,
    PH_LSTEP
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_DEC,
    S_RESP,
    S_LIST
  } state_t;

endpackage

### hw/rtl/sorted_session_table.sv
// sorted session table top level: control sequencer over a chain of entry cells
//
//   channel | signals                  | transfer when
//   --------+--------------------------+------------------------------
//   request | req_valid, req_ready, req | req_valid && req_ready
//   result  | rsp_valid, rsp_ready, rsp | rsp_valid && rsp_ready
//
// one request at a time: accept, a compare step in every cell, a decide step
// (insert/delete shift every cell not below the key by one cell at once,
// update rewrites the matching cell in place), then the result; flush skips
// compare and decide.
// list walks a token along the cells, one result per cycle while rsp drains.
// reset clears the entry count and state; cell contents stay undefined.
// a stalled result holds the sequencer until it is taken.
module sorted_session_table
  import sst_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t state, state_next;
  phase_t phase;

  req_t              cur;
  logic [CNT_W-1:0]  count;
  logic [1:0]        status_r;
  logic [LIST_W-1:0] k;

  entry_t                    ents [TABLE_CAPACITY];
  logic [TABLE_CAPACITY-1:0] lt, eq, um, tok, vld;
  logic [TABLE_CAPACITY-1:0] lt_left, um_left, tok_left, um_next;

  logic   eq_any, um_any, over, full, last_hit, list_last, out_free, req_xfer;
  entry_t sel;
  logic [1:0] dec_status;
  phase_t     dec_phase;

  assign req_xfer = req_valid && req_ready;
  assign out_free = !rsp_valid || rsp_ready;

  // neighbor views; chain ends tie off
  assign lt_left  = {lt[TABLE_CAPACITY-2:0], 1'b1};
  assign um_left  = {um[TABLE_CAPACITY-2:0], 1'b0};
  assign tok_left = {tok[TABLE_CAPACITY-2:0], 1'b0};
  assign um_next  = {1'b0, um[TABLE_CAPACITY-1:1]};

  // the cell chain
  for (genvar i = 0; i < TABLE_CAPACITY; i++) begin : g_cell
    assign vld[i] = CNT_W'(i) < count;
    sst_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .phase     (phase),
      .cmd       (cur),
      .vld       (vld[i]),
      .left_ent  (ents[(i == 0) ? 0 : i - 1]),
      .right_ent (ents[(i == TABLE_CAPACITY - 1) ? i : i + 1]),
      .lt_left   (lt_left[i]),
      .um_left   (um_left[i]),
      .tok_left  (tok_left[i]),
      .ent       (ents[i]),
      .lt        (lt[i]),
      .eq        (eq[i]),
      .um        (um[i]),
      .tok       (tok[i])
    );
  end

  // reductions over the registered cell flags
  assign eq_any = |eq;
  assign um_any = |um;
  assign full   = count == CNT_W'(TABLE_CAPACITY);

  // user entries are contiguous, so the limit is hit when a run of
  // MAX_PER_USER matching cells exists
  always_comb begin
    over = 1'b0;
    for (int i = 0; i + MAX_PER_USER - 1 < TABLE_CAPACITY; i++) begin
      over = over | (um[i] & um[i+MAX_PER_USER-1]);
    end
  end

  // token-selected entry for list output
  always_comb begin
    sel = '0;
    for (int i = 0; i < TABLE_CAPACITY; i++) begin
      if (tok[i]) begin
        sel = sel | ents[i];
      end
    end
  end

  assign last_hit  = |(tok & ~um_next);
  assign list_last = last_hit || (k == LIST_W'(MAX_PER_USER - 1));

  // decision from the compare results
  always_comb begin
    dec_status = ST_OK;
    dec_phase  = PH_IDLE;
    case (cur.req_type)
      REQ_ADD: begin
        if (eq_any) begin
          dec_phase = PH_UPD;
        end else if (full) begin
          dec_status = ST_FULL;
        end else if (over) begin
          dec_status = ST_USER_MAX;
        end else begin
          dec_phase = PH_INS;
        end
      end
      REQ_REMOVE: begin
        if (eq_any) begin
          dec_phase = PH_DEL;
        end else begin
          dec_status = ST_NOT_FOUND;
        end
      end
      REQ_LIST: begin
        if (um_any) begin
          dec_phase = PH_LSTART;
        end else begin
          dec_status = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_xfer) begin
          state_next = (req.req_type == REQ_FLUSH) ? S_RESP : S_CMP;
        end
      end
      S_CMP: state_next = S_DEC;
      S_DEC: state_next = (dec_phase == PH_LSTART) ? S_LIST : S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free && list_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req_ready = 1'b0;
    phase     = PH_IDLE;
    case (state)
      S_IDLE: req_ready = 1'b1;
      S_CMP:  phase = PH_CMP;
      S_DEC:  phase = dec_phase;
      S_LIST: phase = out_free ? PH_LSTEP : PH_IDLE;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && req_xfer && req.req_type == REQ_FLUSH) begin
        count <= '0;
      end else if (state == S_DEC && dec_phase == PH_INS) begin
        count <= count + CNT_W'(1);
      end else if (state == S_DEC && dec_phase == PH_DEL) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // request and status hold
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_xfer) begin
      cur      <= req;
      status_r <= ST_OK;
    end
    if (state == S_DEC) begin
      status_r <= dec_status;
      k        <= '0;
    end
    if (state == S_LIST && out_free) begin
      k <= k + LIST_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_RESP || state == S_LIST) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      rsp.status        <= status_r;
      rsp.out_user_id   <= '0;
      rsp.out_peer_ip   <= '0;
      rsp.out_account   <= '0;
      rsp.out_secret_hi <= '0;
      rsp.out_secret_lo <= '0;
      rsp.out_sequence  <= '0;
      rsp.last          <= 1'b1;
    end else if (state == S_LIST && out_free) begin
      rsp.status        <= ST_OK;
      rsp.out_user_id   <= sel.key[63:32];
      rsp.out_peer_ip   <= sel.key[31:0];
      rsp.out_account   <= sel.account;
      rsp.out_secret_hi <= sel.secret_hi;
      rsp.out_secret_lo <= sel.secret_lo;
      rsp.out_sequence  <= sel.sequence_num + 32'd1;
      rsp.last          <= list_last;
    end
  end

endmodule

### hw/rtl/sst_cell.sv
// one table slot: holds an entry, compares it and shifts with its neighbors
module sst_cell
  import sst_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  phase_t phase,
  input  req_t   cmd,
  input  logic   vld,
  input  entry_t left_ent,
  input  entry_t right_ent,
  input  logic   lt_left,
  input  logic   um_left,
  input  logic   tok_left,
  output entry_t ent,
  output logic   lt,
  output logic   eq,
  output logic   um,
  output logic   tok
);

  logic [63:0] cmd_key;
  entry_t      new_ent;

  assign cmd_key = {cmd.user_id, cmd.peer_ip};

  always_comb begin
    new_ent.key          = cmd_key;
    new_ent.account      = cmd.account_num;
    new_ent.secret_hi    = cmd.secret_hi;
    new_ent.secret_lo    = cmd.secret_lo;
    new_ent.sequence_num = '0;
  end

  // entry payload
  always_ff @(posedge clk) begin
    case (phase)
      PH_INS: begin
        if (!lt) begin
          ent <= lt_left ? new_ent : left_ent;
        end
      end
      PH_DEL: begin
        if (!lt) begin
          ent <= right_ent;
        end
      end
      PH_UPD: begin
        if (eq) begin
          ent.account      <= cmd.account_num;
          ent.secret_hi    <= cmd.secret_hi;
          ent.secret_lo    <= cmd.secret_lo;
          ent.sequence_num <= '0;
        end
      end
      PH_LSTEP: begin
        if (tok) begin
          ent.sequence_num <= ent.sequence_num + 32'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // compare flags
  always_ff @(posedge clk) begin
    if (phase == PH_CMP) begin
      lt <= vld && (ent.key < cmd_key);
      eq <= vld && (ent.key == cmd_key);
      um <= vld && (ent.key[63:32] == cmd.user_id);
    end
  end

  // list token walks right one cell per emitted result
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else if (phase == PH_LSTART) begin
      tok <= um && !um_left;
    end else if (phase == PH_LSTEP) begin
      tok <= tok_left;
    end
  end

endmodule

### tb/sorted_session_table_test.sv
// self-checking testbench for the sorted session table
module sorted_session_table_test
  import sst_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  sorted_session_table i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  // shadow copy of the table, kept sorted by {user, peer}
  entry_t shadow_table[$];
  rsp_t   pending_rsp[$];

  int  error_count;
  int  cycle_count;
  bit  hold_off;      // long receiver stall requested by the pressure test
  bit  stall_enable;  // random stalls on the receiver side
  bit  gap_enable;    // random gaps on the sender side

  localparam int CYCLE_LIMIT = 400000;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // global timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic rsp_t status_only(input logic [1:0] st);
    rsp_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // first slot whose key is not below k
  function automatic int first_at_or_above(input logic [63:0] k);
    int i;
    for (i = 0; i < shadow_table.size(); i++)
      if (shadow_table[i].key >= k) return i;
    return shadow_table.size();
  endfunction

  // apply one request to the shadow table and queue the results it yields
  task automatic predict_session_update(input req_t r);
    logic [63:0] k;
    int pos;
    int n;
    entry_t e;
    rsp_t o;
    k = {r.user_id, r.peer_ip};
    case (r.req_type)
      REQ_FLUSH: begin
        shadow_table.delete();
        pending_rsp.push_back(status_only(ST_OK));
      end
      REQ_LIST: begin
        pos = first_at_or_above({r.user_id, 32'd0});
        n = 0;
        while (pos + n < shadow_table.size() && n < MAX_PER_USER &&
               shadow_table[pos + n].key[63:32] == r.user_id)
          n++;
        if (n == 0) begin
          pending_rsp.push_back(status_only(ST_NOT_FOUND));
        end else begin
          for (int i = 0; i < n; i++) begin
            shadow_table[pos + i].sequence_num = shadow_table[pos + i].sequence_num + 1;
            e = shadow_table[pos + i];
            o.status = ST_OK;
            o.out_user_id = e.key[63:32];
            o.out_peer_ip = e.key[31:0];
            o.out_account = e.account;
            o.out_secret_hi = e.secret_hi;
            o.out_secret_lo = e.secret_lo;
            o.out_sequence = e.sequence_num;
            o.last = (i == n - 1);
            pending_rsp.push_back(o);
          end
        end
      end
      REQ_REMOVE: begin
        pos = first_at_or_above(k);
        if (pos >= shadow_table.size() || shadow_table[pos].key != k) begin
          pending_rsp.push_back(status_only(ST_NOT_FOUND));
        end else begin
          shadow_table.delete(pos);
          pending_rsp.push_back(status_only(ST_OK));
        end
      end
      default: begin
        pos = first_at_or_above(k);
        e.key = k;
        e.account = r.account_num;
        e.secret_hi = r.secret_hi;
        e.secret_lo = r.secret_lo;
        e.sequence_num = '0;
        if (pos < shadow_table.size() && shadow_table[pos].key == k) begin
          shadow_table[pos] = e;
          pending_rsp.push_back(status_only(ST_OK));
        end else if (shadow_table.size() >= TABLE_CAPACITY) begin
          pending_rsp.push_back(status_only(ST_FULL));
        end else begin
          n = 0;
          for (int i = first_at_or_above({r.user_id, 32'd0});
               i < shadow_table.size() && shadow_table[i].key[63:32] == r.user_id; i++)
            n++;
          if (n >= MAX_PER_USER) begin
            pending_rsp.push_back(status_only(ST_USER_MAX));
          end else begin
            shadow_table.insert(pos, e);
            pending_rsp.push_back(status_only(ST_OK));
          end
        end
      end
    endcase
  endtask

  // sender: one request transfer, with a random gap before it when gaps are enabled
  task automatic send_request(input req_t r);
    int gap;
    gap = gap_enable ? $urandom_range(0, 15) : 0;
    repeat (gap) @(negedge clk);
    req_valid = 1'b1;
    req = r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_session_update(r);
    @(negedge clk);
    req_valid = 1'b0;
  endtask

  // receiver ready: random stalls, plus the long hold-off when asked
  int stall_left;
  initial begin
    rsp_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        // after each accepted transfer draw the next stall when stalls are enabled
        if (rsp_valid && rsp_ready && stall_enable) stall_left = $urandom_range(0, 15);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
        if (rsp.out_user_id !== want.out_user_id)
          report_mismatch($sformatf("user %h, want %h", rsp.out_user_id, want.out_user_id));
        if (rsp.out_peer_ip !== want.out_peer_ip)
          report_mismatch($sformatf("peer %h, want %h", rsp.out_peer_ip, want.out_peer_ip));
        if (rsp.out_account !== want.out_account)
          report_mismatch($sformatf("account %h, want %h", rsp.out_account, want.out_account));
        if (rsp.out_secret_hi !== want.out_secret_hi)
          report_mismatch($sformatf("secret hi %h, want %h", rsp.out_secret_hi,
                                    want.out_secret_hi));
        if (rsp.out_secret_lo !== want.out_secret_lo)
          report_mismatch($sformatf("secret lo %h, want %h", rsp.out_secret_lo,
                                    want.out_secret_lo));
        if (rsp.out_sequence !== want.out_sequence)
          report_mismatch($sformatf("sequence %0d, want %0d", rsp.out_sequence,
                                    want.out_sequence));
        if (rsp.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", rsp.last, want.last));
      end
    end
  end

  function automatic req_t make_req(input logic [1:0] kind, input logic [31:0] uid,
                                    input logic [31:0] ip);
    req_t r;
    r.req_type = kind;
    r.user_id = uid;
    r.peer_ip = ip;
    r.account_num = $urandom();
    r.secret_hi = {$urandom(), $urandom()};
    r.secret_lo = {$urandom(), $urandom()};
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  // directed: extremes, every request type, each status but full
  task automatic test_directed();
    req_t r;
    send_request(make_req(REQ_LIST, 32'd5, 32'd0));          // empty user
    send_request(make_req(REQ_REMOVE, 32'd5, 32'd1));        // remove missing
    send_request(make_req(REQ_ADD, '1, '1));                 // all-ones key
    send_request(make_req(REQ_ADD, '0, '0));                 // all-zeros key
    r = make_req(REQ_ADD, 32'd7, 32'd3);
    r.account_num = '1; r.secret_hi = '1; r.secret_lo = '1;
    send_request(r);
    r.account_num = '0; r.secret_hi = '0; r.secret_lo = '0;
    send_request(r);                                         // overwrite existing
    for (int i = 0; i < MAX_PER_USER + 1; i++)               // last one hits the limit
      send_request(make_req(REQ_ADD, 32'd9, 32'(100 - i)));
    send_request(make_req(REQ_LIST, 32'd9, '1));             // max results
    send_request(make_req(REQ_LIST, 32'd9, 32'd0));          // sequence climbs
    send_request(make_req(REQ_REMOVE, 32'd9, 32'd96));
    send_request(make_req(REQ_LIST, '1, 32'd0));
    send_request(make_req(REQ_FLUSH, '1, '1));
    send_request(make_req(REQ_LIST, 32'd9, 32'd0));          // gone after flush
    wait_drained();
  endtask

  // fill to capacity, then a new key is refused as full
  task automatic test_table_full();
    for (int i = 0; i < TABLE_CAPACITY; i++)
      send_request(make_req(REQ_ADD, 32'(i / 4), 32'($urandom())));
    send_request(make_req(REQ_ADD, 32'd3, 32'd0));
    send_request(make_req(REQ_ADD, 32'hffff, 32'd1));
    send_request(make_req(REQ_LIST, 32'd10, 32'd0));
    send_request(make_req(REQ_FLUSH, 32'd0, 32'd0));
    wait_drained();
  endtask

  // random traffic over a small key space so entries collide and get listed
  task automatic test_random_traffic(input int count);
    req_t r;
    logic [31:0] uid;
    logic [31:0] ip;
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      uid = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 5)) << 29;
      ip = ($urandom_range(0, 4) == 0) ? $urandom() : 32'($urandom_range(0, 11)) << 28;
      if (roll < 50) r = make_req(REQ_ADD, uid, ip);
      else if (roll < 70) r = make_req(REQ_REMOVE, uid, ip);
      else if (roll < 97) r = make_req(REQ_LIST, uid, ip);
      else r = make_req(REQ_FLUSH, uid, ip);
      send_request(r);
    end
    wait_drained();
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    int held;
    hold_off = 1'b1;
    fork
      begin
        held = 0;
        while (held < 300) begin
          @(posedge clk);
          held++;
        end
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_request(make_req(REQ_LIST, 32'(i % 2) << 29, 32'd0));
    join
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    error_count = 0;
    cycle_count = 0;
    hold_off = 1'b0;
    stall_enable = 1'b0;
    gap_enable = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    stall_enable = 1'b1;
    gap_enable = 1'b1;
    test_table_full();
    test_random_traffic(10);
    gap_enable = 1'b0;
    test_backpressure();
    gap_enable = 1'b1;
    test_random_traffic(10);

    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sst_pkg.sv
hw/rtl/sst_cell.sv
hw/rtl/sorted_session_table.sv
tb/sorted_session_table_test.sv
